// ===== hw/rtl/tlb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tlb_pkg;

  localparam int unsigned NumLocksC = 16;
  localparam int unsigned SpinW     = 10;
  localparam int unsigned TicketW   = 8;
  localparam int unsigned IndexW    = 4;
  localparam int unsigned BackoffW  = 18;
  localparam int unsigned WideIdxW  = 9;

  localparam logic [SpinW-1:0] SpinResetC = SpinW'(50);

  typedef enum logic [1:0] {
    ActTake    = 2'd0,
    ActPoll    = 2'd1,
    ActTry     = 2'd2,
    ActRelease = 2'd3
  } action_e;

  typedef struct packed {
    logic [TicketW-1:0]  ticket_number;
    logic                granted;
    logic [TicketW-1:0]  waiters_ahead;
    logic [BackoffW-1:0] backoff_count;
    logic                release_error;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tlb_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tlb_core #(
  parameter int unsigned NUM_LOCKS = tlb_pkg::NumLocksC
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          commit_i,
  input  wire tlb_pkg::action_e              action_i,
  input  wire logic [tlb_pkg::IndexW-1:0]    lock_index_i,
  input  wire logic [tlb_pkg::TicketW-1:0]   held_ticket_i,
  input  wire logic [tlb_pkg::SpinW-1:0]     spin_backoff_i,
  output tlb_pkg::result_t                   result_o
);

  localparam int unsigned LockAw = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1;

  logic [tlb_pkg::TicketW-1:0] head_q [NUM_LOCKS];
  logic [tlb_pkg::TicketW-1:0] tail_q [NUM_LOCKS];

  logic [tlb_pkg::WideIdxW-1:0] idx_ext;
  logic                         in_range;
  logic [LockAw-1:0]            addr;
  logic [tlb_pkg::TicketW-1:0]  hd;
  logic [tlb_pkg::TicketW-1:0]  tl;
  logic [tlb_pkg::TicketW-1:0]  tk;
  logic                         is_free;
  logic                         tk_served;
  logic [tlb_pkg::TicketW-1:0]  wait_cnt;
  logic [tlb_pkg::BackoffW-1:0] prod;
  logic                         head_inc;
  logic                         tail_inc;
  tlb_pkg::result_t             res;

  assign idx_ext  = {(tlb_pkg::WideIdxW - tlb_pkg::IndexW)'(0), lock_index_i};
  assign in_range = (idx_ext < tlb_pkg::WideIdxW'(NUM_LOCKS));
  assign addr     = idx_ext[LockAw-1:0];
  assign hd       = in_range ? head_q[addr] : '0;
  assign tl       = in_range ? tail_q[addr] : '0;
  assign is_free  = (hd == tl);

  assign tk        = (action_i == tlb_pkg::ActPoll) ? held_ticket_i : tl;
  assign tk_served = (tk == hd);
  assign wait_cnt  = tk - hd - tlb_pkg::TicketW'(1);
  assign prod      = tlb_pkg::BackoffW'(spin_backoff_i) * tlb_pkg::BackoffW'(wait_cnt);

  always_comb begin
    res      = '0;
    head_inc = 1'b0;
    tail_inc = 1'b0;
    if (in_range) begin
      unique case (action_i)
        tlb_pkg::ActTake: begin
          tail_inc          = 1'b1;
          res.ticket_number = tl;
          res.granted       = tk_served;
          if (!tk_served) begin
            res.waiters_ahead = wait_cnt;
            res.backoff_count = prod;
          end
        end
        tlb_pkg::ActPoll: begin
          res.granted = tk_served;
          if (!tk_served) begin
            res.waiters_ahead = wait_cnt;
            res.backoff_count = prod;
          end
        end
        tlb_pkg::ActTry: begin
          if (is_free) begin
            tail_inc          = 1'b1;
            res.ticket_number = tl;
            res.granted       = 1'b1;
          end
        end
        tlb_pkg::ActRelease: begin
          if (is_free) begin
            res.release_error = 1'b1;
          end else begin
            head_inc = 1'b1;
          end
        end
      endcase
    end
  end

  assign result_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_LOCKS; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
      end
    end else if (commit_i) begin
      if (head_inc) begin
        head_q[addr] <= hd + tlb_pkg::TicketW'(1);
      end
      if (tail_inc) begin
        tail_q[addr] <= tl + tlb_pkg::TicketW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ticket_lock_bank.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel    Direction  Handshake                  Payload
// in         input      in_valid_i / in_ready_o    action_i, lock_index_i, held_ticket_i
// out        output     out_valid_o / out_ready_i  ticket_number_o, granted_o,
//                                                  waiters_ahead_o, backoff_count_o,
//                                                  release_error_o
// config     input      spin_backoff_we_i          spin_backoff_i
//
// One transfer per cycle sustained while the output is not stalled.
// Input register, then one pass of lock lookup, compare and 10x8 multiply into the
// result register; the lock pair is updated on the same edge the result is loaded.
// Reset clears every lock to free and sets spin_backoff to 50.
// A stalled output holds the result; the input register still drains when it frees.

module ticket_lock_bank #(
  parameter int unsigned NUM_LOCKS = tlb_pkg::NumLocksC
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           spin_backoff_we_i,
  input  wire logic [tlb_pkg::SpinW-1:0]      spin_backoff_i,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [1:0]                     action_i,
  input  wire logic [tlb_pkg::IndexW-1:0]     lock_index_i,
  input  wire logic [tlb_pkg::TicketW-1:0]    held_ticket_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [tlb_pkg::TicketW-1:0]         ticket_number_o,
  output logic                                granted_o,
  output logic [tlb_pkg::TicketW-1:0]         waiters_ahead_o,
  output logic [tlb_pkg::BackoffW-1:0]        backoff_count_o,
  output logic                                release_error_o
);

  logic [tlb_pkg::SpinW-1:0]    spin_q;
  logic                         s1_valid_q;
  tlb_pkg::action_e             s1_action_q;
  logic [tlb_pkg::IndexW-1:0]   s1_index_q;
  logic [tlb_pkg::TicketW-1:0]  s1_held_q;
  logic                         out_valid_q;
  tlb_pkg::result_t             res_q;
  tlb_pkg::result_t             res_d;
  logic                         out_free;
  logic                         advance;
  logic                         in_xfer;

  assign out_free   = !out_valid_q || out_ready_i;
  assign advance    = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;
  assign in_xfer    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spin_q <= tlb_pkg::SpinResetC;
    end else if (spin_backoff_we_i) begin
      spin_q <= spin_backoff_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_action_q <= tlb_pkg::action_e'(action_i);
      s1_index_q  <= lock_index_i;
      s1_held_q   <= held_ticket_i;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  tlb_core #(
    .NUM_LOCKS(NUM_LOCKS)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .commit_i      (advance),
    .action_i      (s1_action_q),
    .lock_index_i  (s1_index_q),
    .held_ticket_i (s1_held_q),
    .spin_backoff_i(spin_q),
    .result_o      (res_d)
  );

  assign out_valid_o     = out_valid_q;
  assign ticket_number_o = res_q.ticket_number;
  assign granted_o       = res_q.granted;
  assign waiters_ahead_o = res_q.waiters_ahead;
  assign backoff_count_o = res_q.backoff_count;
  assign release_error_o = res_q.release_error;

endmodule

`default_nettype wire
